FILE: hw/rtl/hpl_pkg.sv
// ----------------------------------------------------------------------------
// hpl_pkg
// Shared types and constants of the hysteresis piecewise linear map.
// ----------------------------------------------------------------------------
package hpl_pkg;

  typedef enum logic [2:0] {
    RG_OFF  = 3'd0,
    RG_LOW  = 3'd1,
    RG_LIN  = 3'd2,
    RG_HIGH = 3'd3,
    RG_MAX  = 3'd4
  } region_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL0,
    BK_MUL1,
    BK_DIV,
    BK_LOAD
  } back_state_e;

  localparam logic [2:0] REG_X_OFF       = 3'd0;
  localparam logic [2:0] REG_X_ON        = 3'd1;
  localparam logic [2:0] REG_X_LIN_LOW   = 3'd2;
  localparam logic [2:0] REG_X_LIN_HIGH  = 3'd3;
  localparam logic [2:0] REG_X_STEP_DOWN = 3'd4;
  localparam logic [2:0] REG_X_STEP_UP   = 3'd5;
  localparam logic [2:0] REG_LOW_LEVELS  = 3'd6;
  localparam logic [2:0] REG_HIGH_LEVELS = 3'd7;

  localparam int unsigned ThrIdxOff      = 0;
  localparam int unsigned ThrIdxOn       = 1;
  localparam int unsigned ThrIdxLinLow   = 2;
  localparam int unsigned ThrIdxLinHigh  = 3;
  localparam int unsigned ThrIdxStepDown = 4;
  localparam int unsigned ThrIdxStepUp   = 5;

  // effective thresholds, index 0 off up to 5 step up
  typedef logic [5:0][15:0] thr_t;

  typedef struct packed {
    logic [15:0] y_max;
    logic [15:0] y_high;
    logic [15:0] y_low;
    logic [15:0] y_off;
  } lvl_t;

  typedef struct packed {
    logic [15:0] sample;
    region_e     region;
  } job_t;

endpackage

FILE: hw/rtl/hpl_fifo.sv
// ----------------------------------------------------------------------------
// hpl_fifo
// Short queue between the front and back parts.
// ----------------------------------------------------------------------------
module hpl_fifo #(
  parameter int unsigned Depth = 2,
  parameter int unsigned Width = 19
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

FILE: hw/rtl/hpl_front.sv
// ----------------------------------------------------------------------------
// hpl_front
// Accepts samples, settles the hysteresis region and queues the item.
// ----------------------------------------------------------------------------
module hpl_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  output logic          full_o,
  input  logic [15:0]   sample_i,
  input  hpl_pkg::thr_t thr_i,
  input  logic          thr_wr_i,
  output logic          q_push_o,
  input  logic          q_full_i,
  output hpl_pkg::job_t q_job_o
);
  import hpl_pkg::*;

  region_e     region_q, region_d;
  logic [15:0] last_q;
  logic        resettle_q;
  logic [15:0] cmp_x;
  logic [5:0]  gt;
  region_e     start_rg, settled;
  logic        accept;

  function automatic region_e step_rg(region_e r, logic [5:0] g);
    region_e n;
    n = r;
    case (r)
      RG_OFF: begin
        if (g[ThrIdxOn]) n = RG_LOW;
      end
      RG_LOW: begin
        if (g[ThrIdxLinLow]) n = RG_LIN;
        else if (!g[ThrIdxOff]) n = RG_OFF;
      end
      RG_LIN: begin
        if (g[ThrIdxLinHigh]) n = RG_HIGH;
        else if (!g[ThrIdxLinLow]) n = RG_LOW;
      end
      RG_HIGH: begin
        if (g[ThrIdxStepUp]) n = RG_MAX;
        else if (!g[ThrIdxLinHigh]) n = RG_LIN;
      end
      RG_MAX: begin
        if (!g[ThrIdxStepDown]) n = RG_HIGH;
      end
      default: begin
        n = RG_OFF;
      end
    endcase
    return n;
  endfunction

  assign cmp_x = resettle_q ? last_q : sample_i;

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      gt[k] = (cmp_x > thr_i[k]);
    end
  end

  // the region moves monotonically, so four moves always settle it
  always_comb begin
    start_rg = resettle_q ? RG_OFF : region_q;
    settled  = start_rg;
    for (int n = 0; n < 5; n++) begin
      settled = step_rg(settled, gt);
    end
  end

  assign full_o   = q_full_i || resettle_q;
  assign accept   = push_i && !full_o;
  assign q_push_o = accept;
  assign q_job_o  = '{sample: sample_i, region: settled};

  always_comb begin
    region_d = region_q;
    if (accept || resettle_q) begin
      region_d = settled;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_q   <= RG_OFF;
      last_q     <= '0;
      resettle_q <= 1'b0;
    end else begin
      region_q   <= region_d;
      resettle_q <= thr_wr_i;
      if (accept) begin
        last_q <= sample_i;
      end
    end
  end

endmodule

FILE: hw/rtl/hpl_back.sv
// ----------------------------------------------------------------------------
// hpl_back
// Maps a settled region to its output level; bit-serial interpolation divide.
// ----------------------------------------------------------------------------
module hpl_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  hpl_pkg::job_t q_job_i,
  output logic          q_pop_o,
  input  hpl_pkg::thr_t thr_i,
  input  hpl_pkg::lvl_t lvl_i,
  output logic          empty_o,
  input  logic          pop_i,
  output logic [15:0]   level_o,
  output logic [2:0]    region_o
);
  import hpl_pkg::*;

  back_state_e state_q, state_d;
  logic [15:0] lo, hi, span, xc, dx;
  logic [15:0] span_q, dx_q;
  logic [31:0] acc_q, acc_d, mul_res, sum;
  logic [15:0] mul_a, mul_b;
  logic [15:0] rem_q, rem_d, sh_q, sh_d;
  logic [16:0] trial;
  logic        trial_ge;
  logic [3:0]  cnt_q, cnt_d;
  logic        out_valid_q, out_valid_d;
  logic [15:0] out_level_q, out_level_d, flat_level;
  region_e     out_region_q, out_region_d;
  logic        out_free, is_lin, cap_en, out_load;

  assign lo     = thr_i[ThrIdxLinLow];
  assign hi     = thr_i[ThrIdxLinHigh];
  assign span   = hi - lo;
  assign xc     = (q_job_i.sample < lo) ? lo : ((q_job_i.sample > hi) ? hi : q_job_i.sample);
  assign dx     = xc - lo;
  assign is_lin = (q_job_i.region == RG_LIN) && (span != '0);
  assign out_free = !out_valid_q || pop_i;

  // level = (y_low*(span-dx) + y_high*dx) / span
  assign mul_a   = (state_q == BK_MUL0) ? lvl_i.y_low : lvl_i.y_high;
  assign mul_b   = (state_q == BK_MUL0) ? (span_q - dx_q) : dx_q;
  assign mul_res = 32'(mul_a) * 32'(mul_b);
  assign sum     = acc_q + mul_res;

  assign trial    = {rem_q, sh_q[15]};
  assign trial_ge = (trial >= {1'b0, span_q});

  always_comb begin
    case (q_job_i.region)
      RG_LOW:  flat_level = lvl_i.y_low;
      RG_LIN:  flat_level = lvl_i.y_low;
      RG_HIGH: flat_level = lvl_i.y_high;
      RG_MAX:  flat_level = lvl_i.y_max;
      default: flat_level = lvl_i.y_off;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (q_valid_i && is_lin) state_d = BK_MUL0;
      end
      BK_MUL0: state_d = BK_MUL1;
      BK_MUL1: state_d = BK_DIV;
      BK_DIV: begin
        if (cnt_q == 4'hf) state_d = BK_LOAD;
      end
      BK_LOAD: begin
        if (out_free) state_d = BK_IDLE;
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    cap_en       = 1'b0;
    out_load     = 1'b0;
    q_pop_o      = 1'b0;
    acc_d        = acc_q;
    rem_d        = rem_q;
    sh_d         = sh_q;
    cnt_d        = cnt_q;
    out_level_d  = out_level_q;
    out_region_d = out_region_q;
    case (state_q)
      BK_IDLE: begin
        if (q_valid_i && is_lin) begin
          cap_en  = 1'b1;
          q_pop_o = 1'b1;
        end else if (q_valid_i && out_free) begin
          q_pop_o      = 1'b1;
          out_load     = 1'b1;
          out_level_d  = flat_level;
          out_region_d = q_job_i.region;
        end
      end
      BK_MUL0: begin
        acc_d = mul_res;
      end
      BK_MUL1: begin
        rem_d = sum[31:16];
        sh_d  = sum[15:0];
        cnt_d = '0;
      end
      BK_DIV: begin
        rem_d = trial_ge ? 16'(trial - {1'b0, span_q}) : trial[15:0];
        sh_d  = {sh_q[14:0], trial_ge};
        cnt_d = cnt_q + 1'b1;
      end
      BK_LOAD: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_level_d  = sh_q;
          out_region_d = RG_LIN;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) out_valid_d = 1'b1;
    else if (pop_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q        <= acc_d;
    rem_q        <= rem_d;
    sh_q         <= sh_d;
    out_level_q  <= out_level_d;
    out_region_q <= out_region_d;
    if (cap_en) begin
      span_q <= span;
      dx_q   <= dx;
    end
  end

  assign empty_o  = !out_valid_q;
  assign level_o  = out_level_q;
  assign region_o = out_region_q;

  a_pop_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> (state_q == BK_IDLE))
    else $error("queue popped outside idle");

  a_rem_below_span : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_DIV) |-> (rem_q < span_q))
    else $error("divider remainder not below span");

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !pop_i) |=> (out_valid_q && $stable(out_level_q)))
    else $error("waiting result overwritten");

  a_lin_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_LOAD) |->
      ((sh_q >= lvl_i.y_low && sh_q <= lvl_i.y_high) ||
       (sh_q <= lvl_i.y_low && sh_q >= lvl_i.y_high)))
    else $error("interpolated level outside flat levels");

endmodule

FILE: hw/rtl/hysteresis_piecewise_linear_map.sv
// ----------------------------------------------------------------------------
// hysteresis_piecewise_linear_map
// Maps samples to levels over five regions with hysteresis and interpolation.
// ----------------------------------------------------------------------------
// Samples enter through a queue interface (push/full) and results leave through
// one (empty/pop). A flat-region item passes the queue and output register, and
// the block sustains one such item per cycle while results are popped; a linear
// item goes through capture, MUL0, MUL1, a restoring divider and load in the
// back end, which takes no new item until it is loaded. Up to QueueDepth
// settled items wait between front and back. Thresholds and levels are written
// over the APB port; after a threshold write full is high for one cycle while
// the region settles again from the last sample.
module hysteresis_piecewise_linear_map #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [15:0] sample_i,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] level_o,
  output logic [2:0]  region_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import hpl_pkg::*;

  logic [5:0][15:0] thr_raw_q;
  logic [31:0]      low_lv_q, high_lv_q;
  thr_t             thr_eff;
  lvl_t             lvl;
  logic [2:0]       reg_idx;
  logic             wr_en, thr_wr;
  logic             q_push, q_full, q_pop, q_empty;
  job_t             q_wjob, q_rjob;
  logic [$bits(job_t)-1:0] q_rdata;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;
  assign thr_wr  = wr_en && (reg_idx <= REG_X_STEP_UP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_raw_q <= '0;
      low_lv_q  <= '0;
      high_lv_q <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_LOW_LEVELS:  low_lv_q  <= pwdata;
        REG_HIGH_LEVELS: high_lv_q <= pwdata;
        default:         thr_raw_q[reg_idx] <= pwdata[15:0];
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_LOW_LEVELS:  prdata = low_lv_q;
      REG_HIGH_LEVELS: prdata = high_lv_q;
      default:         prdata = {16'b0, thr_raw_q[reg_idx]};
    endcase
  end

  // running maximum keeps the thresholds ordered
  always_comb begin
    thr_eff[0] = thr_raw_q[0];
    for (int k = 1; k < 6; k++) begin
      thr_eff[k] = (thr_raw_q[k] > thr_eff[k-1]) ? thr_raw_q[k] : thr_eff[k-1];
    end
  end

  assign lvl = '{y_max:  high_lv_q[31:16], y_high: high_lv_q[15:0],
                 y_low:  low_lv_q[31:16],  y_off:  low_lv_q[15:0]};

  hpl_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .full_o   (full),
    .sample_i (sample_i),
    .thr_i    (thr_eff),
    .thr_wr_i (thr_wr),
    .q_push_o (q_push),
    .q_full_i (q_full),
    .q_job_o  (q_wjob)
  );

  hpl_fifo #(
    .Depth (QueueDepth),
    .Width ($bits(job_t))
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wjob),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .empty_o (q_empty)
  );

  assign q_rjob = job_t'(q_rdata);

  hpl_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (!q_empty),
    .q_job_i   (q_rjob),
    .q_pop_o   (q_pop),
    .thr_i     (thr_eff),
    .lvl_i     (lvl),
    .empty_o   (empty),
    .pop_i     (pop),
    .level_o   (level_o),
    .region_o  (region_o)
  );

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the hysteresis piecewise linear map. Samples go in
// through the push side and every result popped is compared with a region and
// level tracker kept in step with the sample stream and the APB register
// writes. A short hand-picked sequence walks the region boundaries and their
// hysteresis; randomised phases follow, each with its own threshold setting
// (all zero, all ones, sorted, tightly clustered and unsorted) and, but for one
// calm phase, with random idle cycles on both sides of the block.
// ----------------------------------------------------------------------------
module tb_top;
  import hpl_pkg::*;

  localparam int unsigned DrainCycles   = 32;
  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned PhaseItems    = 125;
  localparam int unsigned NumPhases     = 8;

  typedef struct packed {
    logic [15:0] level;
    region_e     region;
  } map_result_t;

  class region_level_tracker;
    logic [15:0]   thr_reg [6];
    logic [31:0]   low_levels;
    logic [31:0]   high_levels;
    region_e       region_now;
    logic [15:0]   last_sample;
    map_result_t   due_results[$];
    int unsigned   mismatches;

    function new();
      foreach (thr_reg[i]) thr_reg[i] = '0;
      low_levels  = '0;
      high_levels = '0;
      region_now  = RG_OFF;
      last_sample = '0;
      mismatches  = 0;
    endfunction

    // running maximum makes the thresholds monotonic
    function thr_t effective_thresholds();
      thr_t t;
      t[ThrIdxOff] = thr_reg[ThrIdxOff];
      for (int i = 1; i < 6; i++) begin
        t[i] = (thr_reg[i] > t[i-1]) ? thr_reg[i] : t[i-1];
      end
      return t;
    endfunction

    function void settle_region();
      thr_t    t;
      region_e r;
      t = effective_thresholds();
      for (int n = 0; n < 8; n++) begin
        r = region_now;
        case (region_now)
          RG_OFF: begin
            if (last_sample > t[ThrIdxOn]) r = RG_LOW;
          end
          RG_LOW: begin
            if (last_sample > t[ThrIdxLinLow]) r = RG_LIN;
            else if (last_sample <= t[ThrIdxOff]) r = RG_OFF;
          end
          RG_LIN: begin
            if (last_sample > t[ThrIdxLinHigh]) r = RG_HIGH;
            else if (last_sample <= t[ThrIdxLinLow]) r = RG_LOW;
          end
          RG_HIGH: begin
            if (last_sample > t[ThrIdxStepUp]) r = RG_MAX;
            else if (last_sample <= t[ThrIdxLinHigh]) r = RG_LIN;
          end
          RG_MAX: begin
            if (last_sample <= t[ThrIdxStepDown]) r = RG_HIGH;
          end
          default: r = RG_OFF;
        endcase
        if (r == region_now) break;
        region_now = r;
      end
    endfunction

    function logic [15:0] level_now();
      thr_t   t;
      longint lo, hi, x, den, tot, ylow, yhigh;
      case (region_now)
        RG_LOW:  return low_levels[31:16];
        RG_HIGH: return high_levels[15:0];
        RG_MAX:  return high_levels[31:16];
        RG_LIN:  ;
        default: return low_levels[15:0];
      endcase
      t     = effective_thresholds();
      ylow  = longint'(low_levels[31:16]);
      yhigh = longint'(high_levels[15:0]);
      lo    = longint'(t[ThrIdxLinLow]);
      hi    = longint'(t[ThrIdxLinHigh]);
      den   = hi - lo;
      if (den <= 0) return low_levels[31:16];
      x = longint'(last_sample);
      if (x < lo) x = lo;
      if (x > hi) x = hi;
      tot = ylow * den + (yhigh - ylow) * (x - lo);
      if (tot < 0) tot = 0;
      tot = tot / den;
      return tot[15:0];
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        REG_LOW_LEVELS:  low_levels = val;
        REG_HIGH_LEVELS: high_levels = val;
        default: begin
          thr_reg[idx] = val[15:0];
          region_now   = RG_OFF;
          settle_region();
        end
      endcase
    endfunction

    function logic [31:0] reg_value(logic [2:0] idx);
      case (idx)
        REG_LOW_LEVELS:  return low_levels;
        REG_HIGH_LEVELS: return high_levels;
        default:         return {16'h0, thr_reg[idx]};
      endcase
    endfunction

    function void note_mismatch(string msg);
      mismatches++;
      if (mismatches <= 10) $display("mismatch: %s", msg);
    endfunction

    function void take_sample(logic [15:0] s);
      last_sample = s;
      settle_region();
      due_results.push_back('{level: level_now(), region: region_now});
    endfunction

    function void match_result(logic [15:0] level, logic [2:0] region);
      map_result_t want;
      if (due_results.size() == 0) begin
        note_mismatch($sformatf("unexpected item level %h region %0d", level, region));
        return;
      end
      want = due_results.pop_front();
      if (want.level !== level || want.region !== region) begin
        note_mismatch($sformatf("expected level %h region %0d, got level %h region %0d",
                                want.level, want.region, level, region));
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic [15:0] sample_i;
  logic        empty;
  logic        pop;
  logic [15:0] level_o;
  logic [2:0]  region_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  bit          calm;
  int unsigned quiet_cycles = 0;
  region_level_tracker tracker = new();

  logic [15:0] s_list [14] = '{16'd150, 16'd201, 16'd150, 16'd100, 16'hFFFF, 16'd8500,
                               16'd8000, 16'd8500, 16'd9001, 16'd3000, 16'd1001,
                               16'd5000, 16'd1000, 16'd0};

  hysteresis_piecewise_linear_map i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .full     (full),
    .sample_i (sample_i),
    .empty    (empty),
    .pop      (pop),
    .level_o  (level_o),
    .region_o (region_o),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  initial begin
    pop = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      pop <= calm || ($urandom_range(99) >= 19);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) tracker.match_result(level_o, region_o);
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || psel) begin
      quiet_cycles <= 0;
    end else if (rst_ni) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // entered and left at a falling edge; push stays high for a following item
  task automatic send_sample(input logic [15:0] s);
    while (!calm && $urandom_range(99) < 19) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push     <= 1'b1;
    sample_i <= s;
    do @(posedge clk_i); while (full);
    tracker.take_sample(s);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (tracker.due_results.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_register(input logic [2:0] idx, input logic [31:0] val);
    logic [31:0] want;
    logic [31:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    tracker.write_reg(idx, val);
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    want = tracker.reg_value(idx);
    got  = (idx <= REG_X_STEP_UP) ? {16'h0, prdata[15:0]} : prdata;
    if (got !== want) begin
      tracker.note_mismatch($sformatf("register %0d read %h, expected %h", idx, got, want));
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic program_map(input thr_t thr, input logic [31:0] lows,
                             input logic [31:0] highs);
    for (int i = 0; i < 6; i++) begin
      write_register(REG_X_OFF + 3'(i), {16'($urandom), thr[i]});
    end
    write_register(REG_LOW_LEVELS, lows);
    write_register(REG_HIGH_LEVELS, highs);
  endtask

  task automatic load_random_setting(input int unsigned kind);
    thr_t        thr;
    logic [31:0] lows;
    logic [31:0] highs;
    lows  = $urandom;
    highs = $urandom;
    case (kind)
      0: begin
        thr   = '0;
        lows  = '0;
        highs = '0;
      end
      1: begin
        thr   = '1;
        lows  = '1;
        highs = '1;
      end
      2: begin
        thr[0] = 16'($urandom_range(20000));
        for (int i = 1; i < 6; i++) thr[i] = thr[i-1] + 16'($urandom_range(6000));
      end
      3: begin
        thr[0] = 16'($urandom_range(65000));
        for (int i = 1; i < 6; i++) thr[i] = thr[i-1] + 16'($urandom_range(40));
      end
      default: begin
        for (int i = 0; i < 6; i++) thr[i] = 16'($urandom);
      end
    endcase
    program_map(thr, lows, highs);
  endtask

  function automatic logic [15:0] pick_sample(logic [15:0] prev);
    thr_t        t;
    int unsigned k;
    int          v;
    t = tracker.effective_thresholds();
    k = $urandom_range(99);
    if (k < 40) v = int'(t[$urandom_range(5)]) + int'($urandom_range(6)) - 3;
    else if (k < 70) v = int'($urandom_range(16'hFFFF));
    else if (k < 90) v = int'(prev) + int'($urandom_range(1024)) - 512;
    else v = $urandom_range(1) ? 65535 : 0;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v[15:0];
  endfunction

  initial begin
    int unsigned kinds [NumPhases];
    logic [15:0] s;
    kinds    = '{2, 0, 3, 1, 4, 2, 3, 4};
    rst_ni   = 1'b0;
    push     = 1'b0;
    sample_i = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    calm     = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset values: all thresholds zero
    send_sample(16'h0000);
    send_sample(16'hFFFF);
    send_sample(16'h0000);
    wait_drained();

    program_map({16'd9000, 16'd8000, 16'd5000, 16'd1000, 16'd200, 16'd100},
                {16'h1000, 16'h0011}, {16'hFFFF, 16'hF000});
    // on/off hysteresis, step up/down hysteresis, then through the linear span
    foreach (s_list[i]) send_sample(s_list[i]);
    wait_drained();

    // falling interpolation
    write_register(REG_LOW_LEVELS, {16'hE000, 16'h0000});
    write_register(REG_HIGH_LEVELS, {16'h0000, 16'h0100});
    send_sample(16'd2500);
    send_sample(16'd4999);
    wait_drained();
    // threshold write settles again from the last sample
    write_register(REG_X_LIN_HIGH, 32'd2000);
    send_sample(16'd2500);
    send_sample(16'd1999);
    wait_drained();

    for (int p = 0; p < NumPhases; p++) begin
      load_random_setting(kinds[p]);
      calm = (p == 2);
      s = 16'($urandom);
      for (int i = 0; i < PhaseItems; i++) begin
        if (p == 4 && i == PhaseItems / 2) wait_drained();
        s = pick_sample(s);
        send_sample(s);
      end
      wait_drained();
      calm = 1'b0;
    end

    if (tracker.mismatches == 0 && tracker.due_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/hpl_pkg.sv
hw/rtl/hpl_fifo.sv
hw/rtl/hpl_front.sv
hw/rtl/hpl_back.sv
hw/rtl/hysteresis_piecewise_linear_map.sv
bench/tb_top.sv
